@@ src/tssdt_pkg.sv @@
// Shared types, constants and helper functions for the SDT packet generator.
// Depends on nothing; the interfaces and the top level import it.
package tssdt_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [8:0] wide_t;
  typedef logic [31:0] crc_t;

  // Packet geometry
  localparam int unsigned PACKET_BYTES = 188;
  localparam int unsigned POS_W        = $clog2(PACKET_BYTES);
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t        LAST_POS     = POS_W'(PACKET_BYTES - 1);

  // Section layout
  localparam wide_t STR_START   = 9'd25;
  localparam wide_t CRC_START   = 9'd5;
  localparam wide_t MAX_STRINGS = 9'd158;

  // Header positions whose byte comes from the configured lengths
  localparam pos_t POS_SECTION_LEN = POS_W'(7);
  localparam pos_t POS_LOOP_LEN    = POS_W'(20);
  localparam pos_t POS_DESC_LEN    = POS_W'(22);
  localparam pos_t POS_PROV_LEN    = POS_W'(24);

  localparam byte_t SECTION_LEN_BASE = 8'h16;
  localparam byte_t LOOP_LEN_BASE    = 8'h05;
  localparam byte_t DESC_LEN_BASE    = 8'h03;
  localparam byte_t FILL_BYTE        = 8'hFF;

  // CRC-32/MPEG-2: no reflection, no final xor
  localparam crc_t CRC_POLY = 32'h04C1_1DB7;
  localparam crc_t CRC_INIT = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_PROV_LEN            = 8'd0;
  localparam cfg_index_t REG_SERVICE_NAME_LENGTH = 8'd1;

  // Fixed header bytes 0..24; length placeholders are zero here
  function automatic byte_t head_byte(input logic [4:0] idx);
    byte_t b;
    case (idx)
      5'd0:    b = 8'h47;
      5'd1:    b = 8'h40;
      5'd2:    b = 8'h11;
      5'd3:    b = 8'h10;
      5'd4:    b = 8'h00;
      5'd5:    b = 8'h42;
      5'd6:    b = 8'hF0;
      5'd7:    b = 8'h00;
      5'd8:    b = 8'h00;
      5'd9:    b = 8'h01;
      5'd10:   b = 8'hC1;
      5'd11:   b = 8'h00;
      5'd12:   b = 8'h00;
      5'd13:   b = 8'h00;
      5'd14:   b = 8'h01;
      5'd15:   b = 8'hFF;
      5'd16:   b = 8'h00;
      5'd17:   b = 8'h01;
      5'd18:   b = 8'hFC;
      5'd19:   b = 8'h80;
      5'd20:   b = 8'h00;
      5'd21:   b = 8'h48;
      5'd22:   b = 8'h00;
      5'd23:   b = 8'h01;
      5'd24:   b = 8'h00;
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

  // One byte of CRC, MSB first
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/tssdt_if.sv @@
// Valid/ready channel interfaces for the SDT packet generator:
// character input, packet byte output and configuration writes. Uses tssdt_pkg.
interface tssdt_char_if import tssdt_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface tssdt_byte_if import tssdt_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t packet_byte;
  byte_t byte_index;
  logic  last_byte;
  logic  wants_char_next;
  logic  length_error;

  modport source (output valid, output packet_byte, output byte_index, output last_byte,
                  output wants_char_next, output length_error, input ready);
  modport sink   (input valid, input packet_byte, input byte_index, input last_byte,
                  input wants_char_next, input length_error, output ready);
endinterface

interface tssdt_cfg_if import tssdt_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  byte_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ts_sdt_packet_generator.sv @@
// SDT transport stream packet generator: one packet byte per character transaction.
// Depends on tssdt_pkg and the channel interfaces in tssdt_if.sv.
//
//   channel  role    payload
//   -------  ------  ---------------------------------------------------------
//   chars    sink    char_byte
//   packet   source  packet_byte, byte_index, last_byte, wants_char_next,
//                    length_error
//   cfg      sink    index, data (0: provider string length, 1: service name length)
//
// One byte per cycle while packet is ready: layout select and bytewise CRC update sit between the
// position/CRC state and the output register, so a byte is registered in the cycle after its character.
// chars is ready whenever the output register is empty or being drained.
// rst (synchronous) clears the lengths, the position and the output valid.
// cfg is always ready; writes to unknown indexes are dropped.
module ts_sdt_packet_generator import tssdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tssdt_cfg_if.sink   cfg,
  tssdt_char_if.sink  chars,
  tssdt_byte_if.source packet
);

  byte_t prov_len;
  byte_t service_name_length;
  pos_t  position;
  crc_t  crc;

  logic  out_valid;
  byte_t out_byte;
  byte_t out_index;
  logic  out_last;
  logic  out_wants;
  logic  out_error;

  logic  accept;
  wide_t sum;
  logic  err;
  pos_t  pos_cur;
  wide_t pos_w;
  wide_t prov_end;
  wide_t crc_pos;
  wide_t crc_off;
  crc_t  crc_cur;
  byte_t byte_next;
  logic  crc_update;
  crc_t  crc_next;
  pos_t  position_next;
  wide_t next_w;
  logic  wants_next;

  assign cfg.ready   = 1'b1;
  assign chars.ready = !out_valid || packet.ready;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prov_len            <= '0;
      service_name_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PROV_LEN:            prov_len            <= cfg.data;
        REG_SERVICE_NAME_LENGTH: service_name_length <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum      = {1'b0, prov_len} + {1'b0, service_name_length};
    err      = sum > MAX_STRINGS;
    pos_cur  = (position > LAST_POS) ? '0 : position;
    pos_w    = {{(9 - POS_W){1'b0}}, pos_cur};
    prov_end = STR_START + {1'b0, prov_len};
    crc_pos  = prov_end + {1'b0, service_name_length} + 9'd1;
    crc_off  = pos_w - crc_pos;
    // reload the CRC at the start of every packet
    crc_cur  = (pos_cur == '0) ? CRC_INIT : crc;

    if (err) begin
      byte_next = FILL_BYTE;
    end else if (pos_w < STR_START) begin
      if (pos_cur == POS_SECTION_LEN) begin
        byte_next = SECTION_LEN_BASE + sum[7:0];
      end else if (pos_cur == POS_LOOP_LEN) begin
        byte_next = LOOP_LEN_BASE + sum[7:0];
      end else if (pos_cur == POS_DESC_LEN) begin
        byte_next = DESC_LEN_BASE + sum[7:0];
      end else if (pos_cur == POS_PROV_LEN) begin
        byte_next = prov_len;
      end else begin
        byte_next = head_byte(pos_w[4:0]);
      end
    end else if (pos_w < prov_end) begin
      byte_next = chars.char_byte;
    end else if (pos_w == prov_end) begin
      byte_next = service_name_length;
    end else if (pos_w < crc_pos) begin
      byte_next = chars.char_byte;
    end else if (pos_w < crc_pos + 9'd4) begin
      // CRC goes out most significant byte first
      case (crc_off[1:0])
        2'd0:    byte_next = crc_cur[31:24];
        2'd1:    byte_next = crc_cur[23:16];
        2'd2:    byte_next = crc_cur[15:8];
        default: byte_next = crc_cur[7:0];
      endcase
    end else begin
      byte_next = FILL_BYTE;
    end

    crc_update = !err && (pos_w >= CRC_START) && (pos_w < crc_pos);
    crc_next   = crc_update ? crc_byte(crc_cur, byte_next) : crc_cur;

    position_next = (pos_cur == LAST_POS) ? '0 : pos_cur + POS_W'(1);
    next_w        = {{(9 - POS_W){1'b0}}, position_next};
    wants_next    = !err &&
                    (((next_w >= STR_START) && (next_w < prov_end)) ||
                     ((next_w > prov_end) && (next_w < crc_pos)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      crc      <= CRC_INIT;
    end else if (accept) begin
      position <= position_next;
      crc      <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (packet.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte  <= byte_next;
      out_index <= 8'(pos_cur);
      out_last  <= (pos_cur == LAST_POS);
      out_wants <= wants_next;
      out_error <= err;
    end
  end

  assign packet.valid           = out_valid;
  assign packet.packet_byte     = out_byte;
  assign packet.byte_index      = out_index;
  assign packet.last_byte       = out_last;
  assign packet.wants_char_next = out_wants;
  assign packet.length_error    = out_error;

`ifndef SYNTHESIS
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= LAST_POS)
    else $error("position left the packet");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && position == LAST_POS |=> position == '0)
    else $error("position did not wrap after the last byte");

  a_error_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_byte == FILL_BYTE && !out_wants)
    else $error("length error byte not filled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_last == (out_index == 8'(LAST_POS)))
    else $error("last byte flag disagrees with index");
`endif

endmodule

@@ verif/sdt_packet_checker.sv @@
// Scoreboard for the SDT packet generator: predicts every packet byte from the
// character and configuration transactions and checks the packet channel.
// Depends on tssdt_pkg and the channel interfaces in src/tssdt_if.sv.
module sdt_packet_checker import tssdt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  tssdt_cfg_if  cfg,
  tssdt_char_if chars,
  tssdt_byte_if packet,
  output int    mismatch_count,
  output int    bytes_pending
);

  typedef struct packed {
    byte_t packet_byte;
    byte_t byte_index;
    logic  last_byte;
    logic  wants_char_next;
    logic  length_error;
  } sdt_byte_t;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned FIRST_CHAR   = STR_START;
  localparam int unsigned CRC_FIRST    = CRC_START;
  localparam int unsigned STRINGS_MAX  = MAX_STRINGS;

  byte_t       provider_len;
  byte_t       name_len;
  int unsigned cur_pos;
  crc_t        section_crc;
  sdt_byte_t   pending_bytes[$];
  int          errors;

  // Header bytes 0..24 with the length slots left at zero
  function automatic byte_t fixed_header(input int unsigned pos);
    byte_t b;
    case (pos)
      0:                    b = 8'h47;
      1:                    b = 8'h40;
      2:                    b = 8'h11;
      3:                    b = 8'h10;
      5:                    b = 8'h42;
      6:                    b = 8'hF0;
      9, 14, 17, 23:        b = 8'h01;
      10:                   b = 8'hC1;
      15:                   b = 8'hFF;
      18:                   b = 8'hFC;
      19:                   b = 8'h80;
      21:                   b = 8'h48;
      default:              b = 8'h00;
    endcase
    return b;
  endfunction

  // Bit-serial CRC-32/MPEG-2, message bit MSB first
  function automatic crc_t crc32_mpeg_update(input crc_t crc, input byte_t b);
    crc_t c;
    logic fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[31] ^ b[k];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic is_char_pos(input int unsigned pos, input int unsigned p,
                                       input int unsigned n);
    return (pos >= FIRST_CHAR && pos < FIRST_CHAR + p) ||
           (pos > FIRST_CHAR + p && pos <= FIRST_CHAR + p + n);
  endfunction

  // Advance position and CRC by one byte and return what the block should emit
  function automatic sdt_byte_t predict_sdt_byte(input byte_t ch);
    int unsigned p, n, total, pos, crc_at, nxt;
    logic        err;
    sdt_byte_t   r;
    p      = provider_len;
    n      = name_len;
    total  = p + n;
    pos    = cur_pos;
    crc_at = FIRST_CHAR + total + 1;
    err    = total > STRINGS_MAX;
    if (pos >= PACKET_BYTES) begin
      pos = 0;
    end
    if (pos == 0) begin
      section_crc = CRC_INIT;
    end
    if (err) begin
      r.packet_byte = FILL_BYTE;
    end else if (pos < FIRST_CHAR) begin
      if (pos == POS_SECTION_LEN) begin
        r.packet_byte = byte_t'(SECTION_LEN_BASE + total);
      end else if (pos == POS_LOOP_LEN) begin
        r.packet_byte = byte_t'(LOOP_LEN_BASE + total);
      end else if (pos == POS_DESC_LEN) begin
        r.packet_byte = byte_t'(DESC_LEN_BASE + total);
      end else if (pos == POS_PROV_LEN) begin
        r.packet_byte = byte_t'(p);
      end else begin
        r.packet_byte = fixed_header(pos);
      end
    end else if (pos < FIRST_CHAR + p) begin
      r.packet_byte = ch;
    end else if (pos == FIRST_CHAR + p) begin
      r.packet_byte = byte_t'(n);
    end else if (pos < crc_at) begin
      r.packet_byte = ch;
    end else if (pos < crc_at + 4) begin
      r.packet_byte = byte_t'(section_crc >> (24 - 8 * (pos - crc_at)));
    end else begin
      r.packet_byte = FILL_BYTE;
    end
    if (!err && pos >= CRC_FIRST && pos < crc_at) begin
      section_crc = crc32_mpeg_update(section_crc, r.packet_byte);
    end
    nxt = (pos + 1 >= PACKET_BYTES) ? 0 : pos + 1;
    r.byte_index      = byte_t'(pos);
    r.last_byte       = (pos == PACKET_BYTES - 1);
    r.wants_char_next = !err && is_char_pos(nxt, p, n);
    r.length_error    = err;
    cur_pos = nxt;
    return r;
  endfunction

  always @(posedge clk) begin
    sdt_byte_t got, want;
    if (rst) begin
      provider_len = '0;
      name_len     = '0;
      cur_pos      = 0;
      section_crc  = CRC_INIT;
      errors       = 0;
      pending_bytes.delete();
    end else begin
      // Retire the oldest expectation before queuing the one for this edge
      if (packet.valid && packet.ready) begin
        got = {packet.packet_byte, packet.byte_index, packet.last_byte,
               packet.wants_char_next, packet.length_error};
        if (pending_bytes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected packet transaction: byte %h index %0d", got.packet_byte,
                     got.byte_index);
          end
        end else begin
          want = pending_bytes.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("packet byte mismatch at %0t", $realtime);
              $display("  expected byte %h index %0d last %b next %b lerr %b",
                       want.packet_byte, want.byte_index, want.last_byte,
                       want.wants_char_next, want.length_error);
              $display("  actual   byte %h index %0d last %b next %b lerr %b",
                       got.packet_byte, got.byte_index, got.last_byte,
                       got.wants_char_next, got.length_error);
            end
          end
        end
      end
      if (chars.valid && chars.ready) begin
        pending_bytes.push_back(predict_sdt_byte(chars.char_byte));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PROV_LEN:            provider_len = cfg.data;
          REG_SERVICE_NAME_LENGTH: name_len     = cfg.data;
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    bytes_pending  <= pending_bytes.size();
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the SDT packet generator: clock, reset, character and
// length stimulus, receiver stalls, watchdog and verdict.
// Depends on tssdt_pkg, src/tssdt_if.sv, the block and sdt_packet_checker.
module testbench import tssdt_pkg::*; ();

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  localparam cfg_index_t  REG_UNMAPPED  = 8'hFF;
  localparam int unsigned STREAM_ITEMS  = 650;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst;
  int          mismatch_count;
  int          bytes_pending;
  int unsigned chars_sent = 0;
  int unsigned idle_cycles = 0;
  logic [5:0]  rx_tick;
  rx_mode_t    rx_mode;

  tssdt_cfg_if  cfg_ch ();
  tssdt_char_if char_ch ();
  tssdt_byte_if pkt_ch ();

  ts_sdt_packet_generator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .chars  (char_ch),
    .packet (pkt_ch)
  );

  sdt_packet_checker byte_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_ch),
    .chars          (char_ch),
    .packet         (pkt_ch),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  always #5 clk = ~clk;

  // Receiver: pick a new random stall pattern each time the 6-bit rx_tick wraps
  always @(posedge clk) begin
    if (rst) begin
      rx_tick      <= '0;
      rx_mode      <= RX_STREAM;
      pkt_ch.ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick == '1) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_STREAM: pkt_ch.ready <= 1'b1;
        RX_COIN:   pkt_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: pkt_ch.ready <= ($urandom_range(0, 5) == 0);
        default:   pkt_ch.ready <= (rx_tick[3:2] != 2'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (pkt_ch.valid && pkt_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_char(input byte_t c);
    char_ch.valid     <= 1'b1;
    char_ch.char_byte <= c;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  // Send a run of random characters in bursts with random gaps
  task automatic send_run(input int unsigned count);
    int unsigned burst, gap;
    while (count > 0) begin
      burst = $urandom_range(1, 48);
      if (burst > count) begin
        burst = count;
      end
      count -= burst;
      repeat (burst) send_char(byte_t'($urandom_range(0, 255)));
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0 && count > 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every packet byte has come back, then let the block settle
  task automatic drain();
    char_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input byte_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lengths(input byte_t p, input byte_t n);
    drain();
    write_reg(REG_PROV_LEN, p);
    write_reg(REG_SERVICE_NAME_LENGTH, n);
  endtask

  initial begin
    int unsigned p, n, run;
    rst               <= 1'b1;
    char_ch.valid     <= 1'b0;
    char_ch.char_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset lengths, dropped write, length extremes, error boundary
    send_char(8'h00);
    send_char(8'hFF);
    drain();
    write_reg(REG_UNMAPPED, 8'hFF);
    send_char(8'hA5);
    set_lengths(8'd158, 8'd0);
    repeat (3) send_char(byte_t'($urandom_range(0, 255)));
    set_lengths(8'd0, 8'd158);
    repeat (2) send_char(byte_t'($urandom_range(0, 255)));
    set_lengths(8'hFF, 8'hFF);
    repeat (3) send_char(byte_t'($urandom_range(0, 255)));
    set_lengths(8'd100, 8'd59);
    repeat (2) send_char(byte_t'($urandom_range(0, 255)));
    set_lengths(8'd79, 8'd79);
    repeat (3) send_char(byte_t'($urandom_range(0, 255)));

    // Random: mostly whole packets per setting, some cut short
    while (chars_sent < STREAM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          p = $urandom_range(1, 255);
          n = (p > 158) ? $urandom_range(0, 255) : $urandom_range(159 - p, 255);
        end
        2: begin
          p = 158;
          n = 0;
        end
        3: begin
          p = 0;
          n = 158;
        end
        4: begin
          p = $urandom_range(0, 158);
          n = 158 - p;
        end
        5: begin
          p = 0;
          n = 0;
        end
        default: begin
          p = $urandom_range(0, 40);
          n = $urandom_range(0, 40);
        end
      endcase
      set_lengths(byte_t'(p), byte_t'(n));
      run = PACKET_BYTES - chars_sent % PACKET_BYTES;
      // stop at the item budget
      if (run > STREAM_ITEMS - chars_sent) begin
        run = STREAM_ITEMS - chars_sent;
      end
      if ($urandom_range(0, 4) == 0) begin
        run = $urandom_range(1, run);
      end
      send_run(run);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
